/* src/gdgc_pkg.sv */
// ---------------------------------------------------------------------------
// gdgc_pkg: shared constants for the geodetic to geocentric converter
// Fixed-point scales, WGS84 axis terms, output limits and the CORDIC
// arctangent step table.
// ---------------------------------------------------------------------------
package gdgc_pkg;

   localparam int CORDIC_STAGES_DEF = 32;

   localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;
   localparam logic [29:0] GAIN_Q30 = 30'd652032874;
   localparam logic [32:0] AXIS_A_MM = 33'd6378137000;
   localparam logic [29:0] ONE_MINUS_F_SQ_Q30 = 30'd1066553788;
   localparam logic [63:0] AXIS_B2_FULL = 64'd6378137000 * 64'd1066553788;
   localparam logic [32:0] AXIS_B2_MM = AXIS_B2_FULL[62:30];
   localparam logic [32:0] RADIUS_MIN = 33'd6000000000;
   localparam logic [32:0] RADIUS_MAX = 33'd6600000000;

   localparam logic [29:0] ATAN_FIRST [0:9] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149
   };

   // arctangent of 2^-i in Q2.30, truncated
   function automatic logic [29:0] atan_step(input int unsigned i);
      logic [29:0] r;
      r = '0;
      if (i < 10) begin
         r = ATAN_FIRST[i[3:0]];
      end else if (i < 30) begin
         r = (30'd1 << (30 - i)) - 30'd1;
      end
      return r;
   endfunction

endpackage

/* src/geodetic_to_geocentric_wgs84_top.sv */
// ---------------------------------------------------------------------------
// geodetic_to_geocentric_wgs84_top: WGS84 geodetic to geocentric pipeline
// Rotation CORDIC, square root, reciprocal, axis scaling and vectoring
// CORDIC, one register stage per step.
// ---------------------------------------------------------------------------
// Usage:
//   Drive req_geodetic_latitude (Q2.30 rad) and req_ellipsoid_height (mm)
//   with start high for one cycle per item. busy is always low, so an item
//   is taken at every clock edge where start is high.
//   Each result appears on rsp_geocentric_latitude (Q2.30 rad) and
//   rsp_geocentric_radius (mm) for exactly one cycle with rsp_valid high.
//   The pipeline holds one input stage, CORDIC_STAGES rotation stages,
//   two multiply stages, 32 square-root stages (one result bit each),
//   one divider setup stage, 32 restoring divider stages (one quotient
//   bit each), four axis-scaling stages, CORDIC_STAGES vectoring stages
//   and two output stages.
//   Throughput is one item per cycle; the items never interact.
//   Reset clears the valid bits of every stage, dropping items in flight.
//   The receiver cannot stall, so the pipeline advances every cycle.
// ---------------------------------------------------------------------------
module geodetic_to_geocentric_wgs84_top #(
   parameter int CORDIC_STAGES = gdgc_pkg::CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_geodetic_latitude,
   input  logic signed [27:0] req_ellipsoid_height,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_geocentric_latitude,
   output logic        [32:0] rsp_geocentric_radius
);

   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 32;
   localparam int LATENCY     = 74 + 2 * CORDIC_STAGES;

   typedef struct packed {
      logic        [30:0] x;
      logic        [30:0] ay;
      logic               yneg;
      logic signed [27:0] h;
   } side_type;

   assign busy = 1'b0;

   // input stage: saturate latitude
   logic               in_v_ff;
   logic signed [31:0] in_lat_ff;
   logic signed [27:0] in_h_ff;
   logic signed [31:0] lat_sat_in;

   always_comb begin
      lat_sat_in = req_geodetic_latitude;
      if (req_geodetic_latitude > gdgc_pkg::HALF_PI_Q30) begin
         lat_sat_in = gdgc_pkg::HALF_PI_Q30;
      end else if (req_geodetic_latitude < -gdgc_pkg::HALF_PI_Q30) begin
         lat_sat_in = -gdgc_pkg::HALF_PI_Q30;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= start;
      end
      in_lat_ff <= lat_sat_in;
      in_h_ff   <= req_ellipsoid_height;
   end

   // rotation CORDIC
   logic               rot_v_ff [1:CORDIC_STAGES];
   logic signed [33:0] rot_x_ff [1:CORDIC_STAGES];
   logic signed [33:0] rot_y_ff [1:CORDIC_STAGES];
   logic signed [33:0] rot_z_ff [1:CORDIC_STAGES];
   logic signed [27:0] rot_h_ff [1:CORDIC_STAGES];

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
      logic               v_d;
      logic signed [33:0] x_d, y_d, z_d;
      logic signed [27:0] h_d;
      logic signed [33:0] xs, ys, at;
      if (k == 0) begin : g_head
         assign v_d = in_v_ff;
         assign x_d = $signed({4'b0, gdgc_pkg::GAIN_Q30});
         assign y_d = '0;
         assign z_d = 34'(in_lat_ff);
         assign h_d = in_h_ff;
      end else begin : g_tail
         assign v_d = rot_v_ff[k];
         assign x_d = rot_x_ff[k];
         assign y_d = rot_y_ff[k];
         assign z_d = rot_z_ff[k];
         assign h_d = rot_h_ff[k];
      end
      assign xs = x_d >>> k;
      assign ys = y_d >>> k;
      assign at = $signed({4'b0, gdgc_pkg::atan_step(k)});
      always_ff @(posedge clock) begin
         if (reset) begin
            rot_v_ff[k+1] <= 1'b0;
         end else begin
            rot_v_ff[k+1] <= v_d;
         end
         if (z_d >= 0) begin
            rot_x_ff[k+1] <= x_d - ys;
            rot_y_ff[k+1] <= y_d + xs;
            rot_z_ff[k+1] <= z_d - at;
         end else begin
            rot_x_ff[k+1] <= x_d + ys;
            rot_y_ff[k+1] <= y_d - xs;
            rot_z_ff[k+1] <= z_d + at;
         end
         rot_h_ff[k+1] <= h_d;
      end
   end

   // clamp cos and sin, square them, weight the sine square by (1-f)^2 and sum
   logic               m1_v_ff, m2_v_ff;
   side_type           m1_side_ff, m2_side_ff;
   logic        [61:0] m1_xx_ff, m1_yy_ff;
   logic        [63:0] m2_q_ff;
   logic signed [33:0] cx, cy;
   side_type           m1_side_in;

   always_comb begin
      cx = rot_x_ff[CORDIC_STAGES];
      cy = rot_y_ff[CORDIC_STAGES];
      if (cx < 0) begin
         cx = '0;
      end else if (cx > $signed({3'b0, gdgc_pkg::ONE_Q30})) begin
         cx = $signed({3'b0, gdgc_pkg::ONE_Q30});
      end
      if (cy > $signed({3'b0, gdgc_pkg::ONE_Q30})) begin
         cy = $signed({3'b0, gdgc_pkg::ONE_Q30});
      end else if (cy < -$signed({3'b0, gdgc_pkg::ONE_Q30})) begin
         cy = -$signed({3'b0, gdgc_pkg::ONE_Q30});
      end
      m1_side_in.x    = cx[30:0];
      m1_side_in.yneg = cy[33];
      m1_side_in.ay   = cy[33] ? 31'(-cy) : cy[30:0];
      m1_side_in.h    = rot_h_ff[CORDIC_STAGES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
      end else begin
         m1_v_ff <= rot_v_ff[CORDIC_STAGES];
         m2_v_ff <= m1_v_ff;
      end
      m1_side_ff <= m1_side_in;
      m1_xx_ff   <= m1_side_in.x * m1_side_in.x;
      m1_yy_ff   <= m1_side_in.ay * m1_side_in.ay;
      m2_side_ff <= m1_side_ff;
      m2_q_ff    <= {2'b0, m1_xx_ff} +
                    ({32'b0, m1_yy_ff[61:30]} * {34'b0, gdgc_pkg::ONE_MINUS_F_SQ_Q30});
   end

   // square root, one result bit per stage
   logic        sq_v_ff    [1:SQRT_STAGES];
   logic [63:0] sq_rem_ff  [1:SQRT_STAGES];
   logic [63:0] sq_res_ff  [1:SQRT_STAGES];
   side_type    sq_side_ff [1:SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic        v_d;
      logic [63:0] rem_d, res_d;
      side_type    side_d;
      logic [63:0] trial;
      if (k == 0) begin : g_head
         assign v_d    = m2_v_ff;
         assign rem_d  = m2_q_ff;
         assign res_d  = '0;
         assign side_d = m2_side_ff;
      end else begin : g_tail
         assign v_d    = sq_v_ff[k];
         assign rem_d  = sq_rem_ff[k];
         assign res_d  = sq_res_ff[k];
         assign side_d = sq_side_ff[k];
      end
      assign trial = res_d + BIT;
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else begin
            sq_v_ff[k+1] <= v_d;
         end
         if (rem_d >= trial) begin
            sq_rem_ff[k+1] <= rem_d - trial;
            sq_res_ff[k+1] <= (res_d >> 1) + BIT;
         end else begin
            sq_rem_ff[k+1] <= rem_d;
            sq_res_ff[k+1] <= res_d >> 1;
         end
         sq_side_ff[k+1] <= side_d;
      end
   end

   // reciprocal 2^60 / root, one quotient bit per stage
   logic        dv_v_ff    [0:DIV_STAGES];
   logic [32:0] dv_rem_ff  [0:DIV_STAGES];
   logic [31:0] dv_quo_ff  [0:DIV_STAGES];
   logic [31:0] dv_den_ff  [0:DIV_STAGES];
   side_type    dv_side_ff [0:DIV_STAGES];
   logic [63:0] root;

   assign root = sq_res_ff[SQRT_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else begin
         dv_v_ff[0] <= sq_v_ff[SQRT_STAGES];
      end
      dv_rem_ff[0]  <= 33'd1 << 28;
      dv_quo_ff[0]  <= '0;
      dv_den_ff[0]  <= (root == 64'd0) ? 32'd1 : root[31:0];
      dv_side_ff[0] <= sq_side_ff[SQRT_STAGES];
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [33:0] t;
      assign t = {dv_rem_ff[k], 1'b0};
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
         if (t >= {2'b0, dv_den_ff[k]}) begin
            dv_rem_ff[k+1] <= 33'(t - {2'b0, dv_den_ff[k]});
            dv_quo_ff[k+1] <= {dv_quo_ff[k][30:0], 1'b1};
         end else begin
            dv_rem_ff[k+1] <= t[32:0];
            dv_quo_ff[k+1] <= {dv_quo_ff[k][30:0], 1'b0};
         end
         dv_den_ff[k+1]  <= dv_den_ff[k];
         dv_side_ff[k+1] <= dv_side_ff[k];
      end
   end

   // axis terms and scaling
   logic               p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff;
   side_type           p1_side_ff, p2_side_ff;
   logic        [34:0] p1_a_ff, p1_b_ff;
   logic        [34:0] p2_c0_ff, p2_s0_ff;
   logic        [35:0] p3_xm_ff, p3_ym_ff;
   logic               p3_yneg_ff;
   logic signed [59:0] p4_vx_ff, p4_vy_ff;
   logic        [64:0] pa, pb;
   logic signed [36:0] c0_sum, s0_sum;
   logic        [65:0] pxm, pym;
   logic signed [59:0] ym_sc;

   assign pa     = gdgc_pkg::AXIS_A_MM * dv_quo_ff[DIV_STAGES];
   assign pb     = gdgc_pkg::AXIS_B2_MM * dv_quo_ff[DIV_STAGES];
   assign c0_sum = $signed({2'b0, p1_a_ff}) + 37'(p1_side_ff.h);
   assign s0_sum = $signed({2'b0, p1_b_ff}) + 37'(p1_side_ff.h);
   assign pxm    = p2_c0_ff * p2_side_ff.x;
   assign pym    = p2_s0_ff * p2_side_ff.ay;
   assign ym_sc  = $signed({4'b0, p3_ym_ff, 20'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= dv_v_ff[DIV_STAGES];
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
      end
      p1_side_ff <= dv_side_ff[DIV_STAGES];
      p1_a_ff    <= pa[64:30];
      p1_b_ff    <= pb[64:30];
      p2_side_ff <= p1_side_ff;
      p2_c0_ff   <= c0_sum[34:0];
      p2_s0_ff   <= s0_sum[34:0];
      p3_xm_ff   <= pxm[65:30];
      p3_ym_ff   <= pym[65:30];
      p3_yneg_ff <= p2_side_ff.yneg;
      p4_vx_ff   <= $signed({4'b0, p3_xm_ff, 20'b0});
      p4_vy_ff   <= p3_yneg_ff ? -ym_sc : ym_sc;
   end

   // vectoring CORDIC
   logic               vec_v_ff [1:CORDIC_STAGES];
   logic signed [59:0] vec_x_ff [1:CORDIC_STAGES];
   logic signed [59:0] vec_y_ff [1:CORDIC_STAGES];
   logic signed [33:0] vec_z_ff [1:CORDIC_STAGES];

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
      logic               v_d;
      logic signed [59:0] x_d, y_d;
      logic signed [33:0] z_d;
      logic signed [59:0] xs, ys;
      logic signed [33:0] at;
      if (k == 0) begin : g_head
         assign v_d = p4_v_ff;
         assign x_d = p4_vx_ff;
         assign y_d = p4_vy_ff;
         assign z_d = '0;
      end else begin : g_tail
         assign v_d = vec_v_ff[k];
         assign x_d = vec_x_ff[k];
         assign y_d = vec_y_ff[k];
         assign z_d = vec_z_ff[k];
      end
      assign xs = x_d >>> k;
      assign ys = y_d >>> k;
      assign at = $signed({4'b0, gdgc_pkg::atan_step(k)});
      always_ff @(posedge clock) begin
         if (reset) begin
            vec_v_ff[k+1] <= 1'b0;
         end else begin
            vec_v_ff[k+1] <= v_d;
         end
         if (y_d >= 0) begin
            vec_x_ff[k+1] <= x_d + ys;
            vec_y_ff[k+1] <= y_d - xs;
            vec_z_ff[k+1] <= z_d + at;
         end else begin
            vec_x_ff[k+1] <= x_d - ys;
            vec_y_ff[k+1] <= y_d + xs;
            vec_z_ff[k+1] <= z_d - at;
         end
      end
   end

   // clamp angle, scale magnitude by the gain, saturate radius
   logic               f1_v_ff;
   logic signed [31:0] f1_lat_ff;
   logic        [69:0] f1_prod_ff;
   logic signed [33:0] zf;
   logic signed [31:0] lat_cl;
   logic signed [59:0] vxf;
   logic        [38:0] rad_full;
   logic        [32:0] rad_sat;

   assign zf  = vec_z_ff[CORDIC_STAGES];
   assign vxf = (vec_x_ff[CORDIC_STAGES] < 0) ? 60'sd0 : vec_x_ff[CORDIC_STAGES];

   always_comb begin
      if (zf > 34'(gdgc_pkg::HALF_PI_Q30)) begin
         lat_cl = gdgc_pkg::HALF_PI_Q30;
      end else if (zf < -34'(gdgc_pkg::HALF_PI_Q30)) begin
         lat_cl = -gdgc_pkg::HALF_PI_Q30;
      end else begin
         lat_cl = zf[31:0];
      end
   end

   assign rad_full = f1_prod_ff[69:31];

   always_comb begin
      if (rad_full < {6'b0, gdgc_pkg::RADIUS_MIN}) begin
         rad_sat = gdgc_pkg::RADIUS_MIN;
      end else if (rad_full > {6'b0, gdgc_pkg::RADIUS_MAX}) begin
         rad_sat = gdgc_pkg::RADIUS_MAX;
      end else begin
         rad_sat = rad_full[32:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         f1_v_ff   <= vec_v_ff[CORDIC_STAGES];
         rsp_valid <= f1_v_ff;
      end
      f1_lat_ff               <= lat_cl;
      f1_prod_ff              <= vxf[58:19] * gdgc_pkg::GAIN_Q30;
      rsp_geocentric_latitude <= f1_lat_ff;
      rsp_geocentric_radius   <= rad_sat;
   end

   // every item taken comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("item lost in pipeline");

   a_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_geocentric_radius >= gdgc_pkg::RADIUS_MIN &&
                     rsp_geocentric_radius <= gdgc_pkg::RADIUS_MAX))
      else $error("radius outside saturation range");

   a_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_geocentric_latitude <= gdgc_pkg::HALF_PI_Q30 &&
                     rsp_geocentric_latitude >= -gdgc_pkg::HALF_PI_Q30))
      else $error("latitude outside quarter turn");

endmodule

/* test/geodetic_to_geocentric_wgs84_top_tb.sv */
// ---------------------------------------------------------------------------
// geodetic_to_geocentric_wgs84_top_tb: self-checking bench for the converter
// Walks a table of directed items, then random latitudes and heights, with
// random gaps on the sender side. Every result is checked against a
// bit-accurate fixed-point predictor of the conversion.
// ---------------------------------------------------------------------------
module geodetic_to_geocentric_wgs84_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAGES = gdgc_pkg::CORDIC_STAGES_DEF;
   localparam int LATENCY = 74 + 2 * STAGES;
   localparam int N_RANDOM = 700;
   localparam int N_DIRECTED = 16;

   typedef struct {
      logic signed [31:0] lat;
      logic [32:0]        radius;
   } geo_type;

   typedef struct {
      logic signed [31:0] lat;
      logic signed [27:0] height;
      bit                 known;
      logic signed [31:0] exp_lat;
      logic [32:0]        exp_radius;
   } row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_geodetic_latitude;
   logic signed [27:0] req_ellipsoid_height;
   logic               rsp_valid;
   logic signed [31:0] rsp_geocentric_latitude;
   logic [32:0]        rsp_geocentric_radius;

   geo_type expected_q[$];
   int      mismatches;
   int      results_seen;
   row_type table_rows[N_DIRECTED];

   geodetic_to_geocentric_wgs84_top dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_geodetic_latitude   (req_geodetic_latitude),
      .req_ellipsoid_height    (req_ellipsoid_height),
      .rsp_valid               (rsp_valid),
      .rsp_geocentric_latitude (rsp_geocentric_latitude),
      .rsp_geocentric_radius   (rsp_geocentric_radius)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("== FAIL ==");
      $finish;
   end

   function automatic longint fshr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_of(int i);
      if (i < 10) begin
         return longint'(gdgc_pkg::ATAN_FIRST[i]);
      end else if (i < 30) begin
         return (longint'(1) << (30 - i)) - 1;
      end
      return 0;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic geo_type convert(logic signed [31:0] lat_in, logic signed [27:0] h_in);
      longint lat, h, x, y, z, xs, ys, c0, s0, vx, vy;
      longint unsigned ay, q, root, cr, ab2, xm, ym, radius;
      geo_type r;
      lat = lat_in;
      h = h_in;
      if (lat > 1686629713) lat = 1686629713;
      if (lat < -1686629713) lat = -1686629713;
      x = 652032874;
      y = 0;
      z = lat;
      for (int i = 0; i < STAGES; i++) begin
         xs = fshr(x, i);
         ys = fshr(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= atan_of(i);
         end else begin
            x += ys; y -= xs; z += atan_of(i);
         end
      end
      if (x < 0) x = 0;
      if (x > 1073741824) x = 1073741824;
      if (y > 1073741824) y = 1073741824;
      if (y < -1073741824) y = -1073741824;
      ay = (y < 0) ? -y : y;
      q = longint'(x) * longint'(x) + ((ay * ay) >> 30) * 64'd1066553788;
      root = root_floor(q);
      if (root == 0) root = 1;
      cr = (64'd1 << 60) / root;
      ab2 = (64'd6378137000 * 64'd1066553788) >> 30;
      c0 = longint'((64'd6378137000 * cr) >> 30) + h;
      s0 = longint'((ab2 * cr) >> 30) + h;
      xm = (longint'(c0) * longint'(x)) >> 30;
      ym = (longint'(s0) * ay) >> 30;
      vx = xm * 1048576;
      vy = ym * 1048576;
      if (y < 0) vy = -vy;
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
         xs = fshr(vx, i);
         ys = fshr(vy, i);
         if (vy >= 0) begin
            vx += ys; vy -= xs; z += atan_of(i);
         end else begin
            vx -= ys; vy += xs; z -= atan_of(i);
         end
      end
      if (z > 1686629713) z = 1686629713;
      if (z < -1686629713) z = -1686629713;
      if (vx < 0) vx = 0;
      radius = ((longint'(vx) >> 19) * 64'd652032874) >> 31;
      if (radius < 64'd6000000000) radius = 64'd6000000000;
      if (radius > 64'd6600000000) radius = 64'd6600000000;
      r.lat = z[31:0];
      r.radius = radius[32:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at result %0d: %s got %0d, expected %0d",
               results_seen, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      geo_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            e = expected_q.pop_front();
            if (rsp_geocentric_latitude !== e.lat)
               report_mismatch("latitude", rsp_geocentric_latitude, e.lat);
            if (rsp_geocentric_radius !== e.radius)
               report_mismatch("radius", rsp_geocentric_radius, e.radius);
         end
         results_seen++;
      end
   end

   function automatic row_type mk(longint lat, longint h);
      row_type r;
      r.lat = lat[31:0];
      r.height = h[27:0];
      r.known = 1'b0;
      r.exp_lat = '0;
      r.exp_radius = '0;
      return r;
   endfunction

   // queue the item and put it on the ports for the coming edge
   task automatic send_item(logic signed [31:0] lat, logic signed [27:0] h, geo_type e,
                            int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_geodetic_latitude <= lat;
      req_ellipsoid_height <= h;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_q.insert(expected_q.size(), e);
   endtask

   initial begin
      geo_type e;
      int idle_pct;
      longint lat, h;
      mismatches = 0;
      results_seen = 0;
      start = 1'b0;
      reset = 1'b1;
      req_geodetic_latitude = '0;
      req_ellipsoid_height = '0;

      table_rows[0] = mk(0, 0);
      table_rows[1] = mk(1686629713, 0);
      table_rows[2] = mk(-1686629713, 0);
      // beyond a quarter turn: saturated on entry
      table_rows[3] = mk(2147483647, 0);
      table_rows[4] = mk(-2147483648, 0);
      table_rows[5] = mk(0, 100000000);
      table_rows[6] = mk(0, -100000000);
      table_rows[7] = mk(0, 134217727);
      table_rows[8] = mk(0, -134217728);
      // extreme heights at the pole and at the equator
      table_rows[9] = mk(1686629713, -134217728);
      table_rows[10] = mk(0, 134217727);
      table_rows[11] = mk(843314856, 12345);
      table_rows[12] = mk(-843314856, -12345);
      table_rows[13] = mk(1686000000, 0);
      table_rows[14] = mk(1, 1);
      table_rows[15] = mk(-1, -1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         e = convert(table_rows[i].lat, table_rows[i].height);
         if (table_rows[i].known) begin
            // hand-typed latitude; radius too where given
            e.lat = table_rows[i].exp_lat;
            if (table_rows[i].exp_radius != 0) e.radius = table_rows[i].exp_radius;
         end
         send_item(table_rows[i].lat, table_rows[i].height, e, 19);
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         idle_pct = (n >= 250 && n < 400) ? 0 : 19;
         case ($urandom_range(9))
            0: lat = $signed($urandom());
            1: lat = $urandom_range(1686629713, 1686000000);
            2: lat = -longint'($urandom_range(1686629713, 1686000000));
            default: lat = longint'($urandom_range(2 * 32'd1686629713)) - 1686629713;
         endcase
         case ($urandom_range(4))
            0: h = longint'($signed($urandom() & 32'h0fff_ffff) <<< 4) >>> 4;
            1: h = longint'($urandom_range(2000)) - 1000;
            default: h = longint'($urandom_range(200000000)) - 100000000;
         endcase
         e = convert(lat[31:0], h[27:0]);
         send_item(lat[31:0], h[27:0], e, idle_pct);
      end
      start <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);

      $display("covered %0d directed and %0d random conversions, %0d results checked",
               N_DIRECTED, N_RANDOM, results_seen);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/gdgc_pkg.sv
src/geodetic_to_geocentric_wgs84_top.sv
test/geodetic_to_geocentric_wgs84_top_tb.sv
